/* sv/mbs_pkg.sv */
// shared constants and fixed-point helpers for the minimum bracket search
package mbs_pkg;

    localparam int PW = 32;
    localparam int FB = 16;
    localparam int DVD_W = PW + FB;

    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
    // golden ratio 1.618034 rounded to the nearest Q step
    localparam logic signed [PW-1:0] GOLD_Q = 32'sd106039;
    localparam logic signed [PW-1:0] LIMIT_FACTOR = 32'sd100;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_VALUE = 1'b1;
    localparam logic KIND_EVAL = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    function automatic logic signed [PW-1:0] sat33(input logic signed [PW:0] x);
        logic signed [PW-1:0] r;
        if (x > $signed({PMAX[PW-1], PMAX})) r = PMAX;
        else if (x < $signed({PMIN[PW-1], PMIN})) r = PMIN;
        else r = x[PW-1:0];
        return r;
    endfunction

    function automatic logic signed [PW-1:0] sat64(input logic signed [2*PW-1:0] x);
        logic signed [PW-1:0] r;
        if (x > 64'(PMAX)) r = PMAX;
        else if (x < 64'(PMIN)) r = PMIN;
        else r = x[PW-1:0];
        return r;
    endfunction

    function automatic logic signed [PW-1:0] dif(input logic signed [PW-1:0] x,
                                                  input logic signed [PW-1:0] y);
        return sat33(33'(x) - 33'(y));
    endfunction

    function automatic logic signed [PW-1:0] add(input logic signed [PW-1:0] x,
                                                  input logic signed [PW-1:0] y);
        return sat33(33'(x) + 33'(y));
    endfunction

    // floor(product / 2^FB), saturated
    function automatic logic signed [PW-1:0] mulsat(input logic signed [2*PW-1:0] p);
        return sat64(p >>> FB);
    endfunction

    function automatic logic signed [PW-1:0] clamp0(input logic signed [PW-1:0] x);
        return x[PW-1] ? '0 : x;
    endfunction

endpackage

/* sv/minimum_bracket_search.sv */
// minimum bracket search sequencer with one shared multiplier and a serial divider
//
//   channel | direction | ports
//   s_      | in        | s_valid s_ready s_req_type s_start_a s_start_b s_func_value
//   m_      | out       | m_valid m_ready m_out_kind m_eval_point m_bracket_* m_value_*
//
// a start beat or a value beat that needs no parabola gives a result without the divider
// a value beat that reaches the parabola step runs through the
// 48-step restoring divider and the serial use of the one 32x32 multiplier
// s_ready is low while an item is at work or while a result beat waits on m_ready
// aresetn is synchronous, active low; it clears the sequencer and the search phase
module minimum_bracket_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic signed [31:0] s_start_a,
    input  logic signed [31:0] s_start_b,
    input  logic signed [31:0] s_func_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic signed [31:0] m_eval_point,
    output logic signed [31:0] m_bracket_a,
    output logic signed [31:0] m_bracket_b,
    output logic signed [31:0] m_bracket_c,
    output logic signed [31:0] m_value_a,
    output logic signed [31:0] m_value_b,
    output logic signed [31:0] m_value_c
);

    localparam int PW = mbs_pkg::PW;
    localparam int DW = mbs_pkg::DVD_W;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_A, PH_WAIT_B, PH_WAIT_C, PH_INNER, PH_OUTER, PH_STEP
    } phase_t;

    typedef enum logic [3:0] {
        S_IN, S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_DSET, S_DIV,
        S_H7, S_H8, S_G1, S_G2, S_DONE
    } seq_t;

    seq_t   state_reg;
    phase_t phase_reg, gphase_reg;
    logic   m_valid_reg;

    logic signed [PW-1:0] a_reg, b_reg, c_reg, fa_reg, fb_reg, fc_reg;
    logic signed [PW-1:0] trial_reg, ulim_reg, u_reg;
    logic signed [PW-1:0] mx_reg, my_reg, r_reg, q_reg, t_reg, num_reg, gbase_reg;
    logic signed [2*PW-1:0] prod_reg;
    logic gclamp_reg, gset_c_reg, qneg_reg;

    logic [DW-1:0] dvd_reg;
    logic [PW:0]   dvs_reg, rem_reg;
    logic [5:0]    cnt_reg;

    logic        kind_reg;
    logic signed [PW-1:0] o_eval_reg, o_a_reg, o_b_reg, o_c_reg, o_fa_reg, o_fb_reg, o_fc_reg;

    // combinational helpers
    logic signed [PW-1:0] prod_q, d_val, d_mag, num_mag, quot, gsum, gout;
    logic signed [PW-1:0] swap_a, swap_b, swap_fa, swap_fb;
    logic signed [PW+2:0] rem_diff;
    logic [PW+1:0] rem_sh;
    logic in_acc, inner_hit, outer_hit, lim_hit;

    assign in_acc = s_valid && s_ready;
    assign prod_q = mbs_pkg::mulsat(prod_reg);

    always_comb begin
        d_val = mbs_pkg::dif(q_reg, r_reg);
        if (d_val[PW-1]) d_mag = (d_val == mbs_pkg::PMIN) ? mbs_pkg::PMAX : -d_val;
        else d_mag = d_val;
        if (d_mag == '0) d_mag = PW'(1);
        num_mag = num_reg[PW-1] ? -num_reg : num_reg;
    end

    always_comb begin
        if (qneg_reg) begin
            if (dvd_reg > DW'(48'd2147483648)) quot = mbs_pkg::PMIN;
            else quot = -$signed(dvd_reg[PW-1:0]);
        end else begin
            if (dvd_reg > DW'(mbs_pkg::PMAX)) quot = mbs_pkg::PMAX;
            else quot = $signed(dvd_reg[PW-1:0]);
        end
    end

    assign rem_sh   = {rem_reg, dvd_reg[DW-1]};
    assign rem_diff = $signed({1'b0, rem_sh}) - $signed({2'b00, dvs_reg});

    assign inner_hit = (b_reg > u_reg && u_reg > c_reg) || (b_reg < u_reg && u_reg < c_reg);
    assign outer_hit = (c_reg > u_reg && u_reg > ulim_reg) ||
                       (c_reg < u_reg && u_reg < ulim_reg);
    assign lim_hit   = !((u_reg > ulim_reg && ulim_reg < c_reg) ||
                         (u_reg < ulim_reg && ulim_reg > c_reg));

    assign gsum = mbs_pkg::add(gbase_reg, prod_q);
    assign gout = gclamp_reg ? mbs_pkg::clamp0(gsum) : gsum;

    // walk downhill: swap so that f(b) <= f(a)
    always_comb begin
        if (s_func_value > fa_reg) begin
            swap_a = b_reg; swap_b = a_reg; swap_fa = s_func_value; swap_fb = fa_reg;
        end else begin
            swap_a = a_reg; swap_b = b_reg; swap_fa = fa_reg; swap_fb = s_func_value;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mx_reg * my_reg;
        if (!aresetn) begin
            state_reg   <= S_IN;
            phase_reg   <= PH_IDLE;
            gphase_reg  <= PH_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IN: begin
                    if (in_acc) begin
                        if (s_req_type == mbs_pkg::REQ_START) begin
                            a_reg <= s_start_a; b_reg <= s_start_b; c_reg <= '0;
                            fa_reg <= '0; fb_reg <= '0; fc_reg <= '0;
                            ulim_reg <= '0;
                            phase_reg <= PH_WAIT_A;
                            trial_reg <= s_start_a;
                            m_valid_reg <= 1'b1; kind_reg <= mbs_pkg::KIND_EVAL;
                            o_eval_reg <= s_start_a;
                        end else begin
                            case (phase_reg)
                                PH_WAIT_A: begin
                                    fa_reg <= s_func_value;
                                    phase_reg <= PH_WAIT_B;
                                    trial_reg <= b_reg;
                                    m_valid_reg <= 1'b1; kind_reg <= mbs_pkg::KIND_EVAL;
                                    o_eval_reg <= b_reg;
                                end
                                PH_WAIT_B: begin
                                    a_reg <= swap_a; b_reg <= swap_b;
                                    fa_reg <= swap_fa; fb_reg <= swap_fb;
                                    mx_reg <= mbs_pkg::GOLD_Q;
                                    my_reg <= mbs_pkg::dif(swap_b, swap_a);
                                    gbase_reg <= swap_b;
                                    gclamp_reg <= 1'b1; gset_c_reg <= 1'b1;
                                    gphase_reg <= PH_WAIT_C;
                                    state_reg <= S_G1;
                                end
                                PH_WAIT_C: begin
                                    fc_reg <= s_func_value;
                                    state_reg <= S_H0;
                                end
                                PH_INNER: begin
                                    if (s_func_value < fc_reg) begin
                                        a_reg <= b_reg; b_reg <= trial_reg;
                                        fa_reg <= fb_reg; fb_reg <= s_func_value;
                                        state_reg <= S_DONE;
                                    end else if (s_func_value > fb_reg) begin
                                        c_reg <= trial_reg; fc_reg <= s_func_value;
                                        state_reg <= S_DONE;
                                    end else begin
                                        mx_reg <= mbs_pkg::GOLD_Q;
                                        my_reg <= mbs_pkg::dif(c_reg, b_reg);
                                        gbase_reg <= c_reg;
                                        gclamp_reg <= 1'b1; gset_c_reg <= 1'b0;
                                        gphase_reg <= PH_STEP;
                                        state_reg <= S_G1;
                                    end
                                end
                                PH_OUTER: begin
                                    if (s_func_value < fc_reg) begin
                                        b_reg <= c_reg; c_reg <= trial_reg;
                                        fb_reg <= fc_reg; fc_reg <= s_func_value;
                                        // golden-ratio step after a good extrapolation, no clamp
                                        mx_reg <= mbs_pkg::GOLD_Q;
                                        my_reg <= mbs_pkg::dif(trial_reg, c_reg);
                                        gbase_reg <= trial_reg;
                                        gclamp_reg <= 1'b0; gset_c_reg <= 1'b0;
                                        gphase_reg <= PH_STEP;
                                        state_reg <= S_G1;
                                    end else begin
                                        a_reg <= b_reg; b_reg <= c_reg; c_reg <= trial_reg;
                                        fa_reg <= fb_reg; fb_reg <= fc_reg;
                                        fc_reg <= s_func_value;
                                        state_reg <= S_H0;
                                    end
                                end
                                PH_STEP: begin
                                    a_reg <= b_reg; b_reg <= c_reg; c_reg <= trial_reg;
                                    fa_reg <= fb_reg; fb_reg <= fc_reg;
                                    fc_reg <= s_func_value;
                                    state_reg <= S_H0;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_H0: begin
                    if (!(fb_reg > fc_reg)) begin
                        state_reg <= S_DONE;
                    end else begin
                        mx_reg <= mbs_pkg::dif(b_reg, a_reg);
                        my_reg <= mbs_pkg::dif(fb_reg, fc_reg);
                        state_reg <= S_H1;
                    end
                end
                S_H1: begin
                    mx_reg <= mbs_pkg::dif(b_reg, c_reg);
                    my_reg <= mbs_pkg::dif(fb_reg, fa_reg);
                    state_reg <= S_H2;
                end
                S_H2: begin
                    r_reg <= prod_q;
                    state_reg <= S_H3;
                end
                S_H3: begin
                    q_reg <= prod_q;
                    mx_reg <= mbs_pkg::dif(b_reg, c_reg);
                    my_reg <= prod_q;
                    state_reg <= S_H4;
                end
                S_H4: begin
                    mx_reg <= mbs_pkg::dif(b_reg, a_reg);
                    my_reg <= r_reg;
                    state_reg <= S_H5;
                end
                S_H5: begin
                    t_reg <= prod_q;
                    state_reg <= S_H6;
                end
                S_H6: begin
                    num_reg <= mbs_pkg::dif(t_reg, prod_q);
                    // product settles on 100 * (c - b) during the division
                    mx_reg <= mbs_pkg::dif(c_reg, b_reg);
                    my_reg <= mbs_pkg::LIMIT_FACTOR;
                    state_reg <= S_DSET;
                end
                S_DSET: begin
                    dvd_reg <= {num_mag, {mbs_pkg::FB{1'b0}}};
                    dvs_reg <= {d_mag, 1'b0};
                    rem_reg <= '0;
                    // a flat parabola (zero denominator) counts its denominator as negative
                    qneg_reg <= num_reg[PW-1] ^ !(d_val > 0);
                    cnt_reg <= 6'(DW - 1);
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!rem_diff[PW+2]) begin
                        rem_reg <= rem_diff[PW:0];
                        dvd_reg <= {dvd_reg[DW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[PW:0];
                        dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) state_reg <= S_H7;
                end
                S_H7: begin
                    u_reg <= mbs_pkg::clamp0(mbs_pkg::dif(b_reg, quot));
                    ulim_reg <= mbs_pkg::add(b_reg, mbs_pkg::sat64(prod_reg));
                    state_reg <= S_H8;
                end
                S_H8: begin
                    if (inner_hit || outer_hit || lim_hit) begin
                        if (inner_hit) begin
                            phase_reg <= PH_INNER;
                            trial_reg <= u_reg; o_eval_reg <= u_reg;
                        end else if (outer_hit) begin
                            phase_reg <= PH_OUTER;
                            trial_reg <= u_reg; o_eval_reg <= u_reg;
                        end else begin
                            phase_reg <= PH_STEP;
                            trial_reg <= mbs_pkg::clamp0(ulim_reg);
                            o_eval_reg <= mbs_pkg::clamp0(ulim_reg);
                        end
                        m_valid_reg <= 1'b1; kind_reg <= mbs_pkg::KIND_EVAL;
                        state_reg <= S_IN;
                    end else begin
                        mx_reg <= mbs_pkg::GOLD_Q;
                        my_reg <= mbs_pkg::dif(c_reg, b_reg);
                        gbase_reg <= c_reg;
                        gclamp_reg <= 1'b1; gset_c_reg <= 1'b0;
                        gphase_reg <= PH_STEP;
                        state_reg <= S_G1;
                    end
                end
                S_G1: state_reg <= S_G2;
                S_G2: begin
                    trial_reg <= gout;
                    if (gset_c_reg) c_reg <= gout;
                    phase_reg <= gphase_reg;
                    m_valid_reg <= 1'b1; kind_reg <= mbs_pkg::KIND_EVAL;
                    o_eval_reg <= gout;
                    state_reg <= S_IN;
                end
                S_DONE: begin
                    m_valid_reg <= 1'b1; kind_reg <= mbs_pkg::KIND_DONE;
                    phase_reg <= PH_IDLE;
                    state_reg <= S_IN;
                end
                default: state_reg <= S_IN;
            endcase
        end
    end

    // payload lanes other than the point are zero on an evaluation beat
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE) begin
            o_a_reg <= a_reg; o_b_reg <= b_reg; o_c_reg <= c_reg;
            o_fa_reg <= fa_reg; o_fb_reg <= fb_reg; o_fc_reg <= fc_reg;
        end else if (!m_valid_reg) begin
            o_a_reg <= '0; o_b_reg <= '0; o_c_reg <= '0;
            o_fa_reg <= '0; o_fb_reg <= '0; o_fc_reg <= '0;
        end
    end

    assign s_ready      = (state_reg == S_IN) && !m_valid_reg;
    assign m_valid      = m_valid_reg;
    assign m_out_kind   = kind_reg;
    assign m_eval_point = (kind_reg == mbs_pkg::KIND_DONE) ? '0 : o_eval_reg;
    assign m_bracket_a  = o_a_reg;
    assign m_bracket_b  = o_b_reg;
    assign m_bracket_c  = o_c_reg;
    assign m_value_a    = o_fa_reg;
    assign m_value_b    = o_fb_reg;
    assign m_value_c    = o_fc_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IN))
        else $error("ready outside input state");
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == mbs_pkg::KIND_DONE) |-> (phase_reg == PH_IDLE))
        else $error("bracket beat while search active");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DSET) |=> (state_reg == S_DIV && cnt_reg == 6'(DW - 1)))
        else $error("divider not loaded");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg && $stable(o_eval_reg))
        else $error("result beat dropped");

endmodule
